// ===== sv/mbds_pkg.sv =====
// ----------------------------------------------------------------------------
// mbds_pkg
// Shared constants, types and helpers for the multi-byte delimiter stuffer.
// ----------------------------------------------------------------------------
package mbds_pkg;

    localparam int MAX_PATTERN_BYTES = 4;
    localparam int PAT_LIMIT  = (MAX_PATTERN_BYTES < 4) ? MAX_PATTERN_BYTES : 4;
    localparam int WIN_DEPTH  = MAX_PATTERN_BYTES - 1;
    localparam int FILL_W     = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W      = $clog2(MAX_PATTERN_BYTES);
    localparam int LEN_W      = $clog2(PAT_LIMIT + 1);
    localparam int K_W        = (PAT_LIMIT > 1) ? $clog2(PAT_LIMIT) : 1;
    localparam int CFG_LEN_W  = 3;
    localparam int ADDR_W     = 5;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] t_win;

    typedef enum logic [2:0] {
        REG_START_PAT  = 3'd0,
        REG_START_LEN  = 3'd1,
        REG_END_PAT    = 3'd2,
        REG_END_LEN    = 3'd3,
        REG_ESC_PAT    = 3'd4,
        REG_ESC_LEN    = 3'd5,
        REG_STUFF_PAT  = 3'd6,
        REG_STUFF_LEN  = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_END   = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_STORE,
        CLS_RELEASE,
        CLS_BEGIN,
        CLS_END
    } t_cls;

    typedef enum logic [1:0] {
        SRC_START,
        SRC_END,
        SRC_STUFF,
        SRC_HEAD
    } t_src;

    typedef struct packed {
        logic [31:0]          start_pat;
        logic [CFG_LEN_W-1:0] start_len;
        logic [31:0]          end_pat;
        logic [CFG_LEN_W-1:0] end_len;
        logic [31:0]          esc_pat;
        logic [CFG_LEN_W-1:0] esc_len;
        logic [31:0]          stuff_pat;
        logic [CFG_LEN_W-1:0] stuff_len;
    } t_cfg;

    // sequencer to datapath
    typedef struct packed {
        logic           accept;
        t_cls           cls;
        logic           emit;
        t_src           src;
        logic [K_W-1:0] k;
        logic           shift;
        logic           finish;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic             in_frame;
        logic             fill_full;
        logic             fill_nz;
        logic             item_end;
        logic             match_start;
        logic             match_end;
        logic             match_esc;
        logic             push_ok;
        logic [LEN_W-1:0] len_start;
        logic [LEN_W-1:0] len_end;
        logic [LEN_W-1:0] len_stuff;
    } t_stat;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        if (len > CFG_LEN_W'(PAT_LIMIT)) begin
            r = LEN_W'(PAT_LIMIT);
        end else begin
            r = LEN_W'(len);
        end
        return r;
    endfunction

endpackage

// ===== sv/mbds_regs.sv =====
// ----------------------------------------------------------------------------
// mbds_regs
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module mbds_regs
    import mbds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_pat <= '0;
            r_cfg.start_len <= '0;
            r_cfg.end_pat   <= '0;
            r_cfg.end_len   <= '0;
            r_cfg.esc_pat   <= 32'h0063_7365;
            r_cfg.esc_len   <= CFG_LEN_W'(3);
            r_cfg.stuff_pat <= '0;
            r_cfg.stuff_len <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_START_PAT: r_cfg.start_pat <= pwdata;
                REG_START_LEN: r_cfg.start_len <= pwdata[CFG_LEN_W-1:0];
                REG_END_PAT:   r_cfg.end_pat   <= pwdata;
                REG_END_LEN:   r_cfg.end_len   <= pwdata[CFG_LEN_W-1:0];
                REG_ESC_PAT:   r_cfg.esc_pat   <= pwdata;
                REG_ESC_LEN:   r_cfg.esc_len   <= pwdata[CFG_LEN_W-1:0];
                REG_STUFF_PAT: r_cfg.stuff_pat <= pwdata;
                REG_STUFF_LEN: r_cfg.stuff_len <= pwdata[CFG_LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_START_PAT: prdata = r_cfg.start_pat;
            REG_START_LEN: prdata = 32'(r_cfg.start_len);
            REG_END_PAT:   prdata = r_cfg.end_pat;
            REG_END_LEN:   prdata = 32'(r_cfg.end_len);
            REG_ESC_PAT:   prdata = r_cfg.esc_pat;
            REG_ESC_LEN:   prdata = 32'(r_cfg.esc_len);
            REG_STUFF_PAT: prdata = r_cfg.stuff_pat;
            REG_STUFF_LEN: prdata = 32'(r_cfg.stuff_len);
        endcase
    end

endmodule

// ===== sv/mbds_dp.sv =====
// ----------------------------------------------------------------------------
// mbds_dp
// Datapath: lookahead window, pattern compare, hold byte and output register.
// ----------------------------------------------------------------------------
module mbds_dp
    import mbds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_ctl        i_ctl,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_stall,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_frame_done
);

    t_win              r_win;
    logic [FILL_W-1:0] r_fill;
    logic              r_inside;
    logic              r_item_end;
    logic              r_pend_v;
    logic [7:0]        r_pend_byte;
    logic              r_out_v;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_fd;

    logic [7:0]        sel_byte;
    logic              out_free;
    logic              push;
    logic [K_W+2:0]    base;

    function automatic logic f_match(input logic [31:0] pat, input logic [LEN_W-1:0] n,
                                     input t_win win, input logic [FILL_W-1:0] fill);
        logic m;
        m = (FILL_W'(n) <= fill);
        for (int k = 0; k < PAT_LIMIT; k++) begin
            if ((k < int'(n)) && (win[k] != pat[8*k +: 8])) begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

    assign base = {i_ctl.k, 3'b000};

    always_comb begin
        unique case (i_ctl.src)
            SRC_START: sel_byte = i_cfg.start_pat[base +: 8];
            SRC_END:   sel_byte = i_cfg.end_pat[base +: 8];
            SRC_STUFF: sel_byte = i_cfg.stuff_pat[base +: 8];
            SRC_HEAD:  sel_byte = r_win[0];
        endcase
    end

    assign out_free = !r_out_v || !i_out_stall;
    assign push     = (i_ctl.emit || i_ctl.finish) && r_pend_v;

    always_comb begin
        o_stat.in_frame    = r_inside;
        o_stat.fill_full   = (r_fill == FILL_W'(WIN_DEPTH));
        o_stat.fill_nz     = (r_fill != '0);
        o_stat.item_end    = r_item_end;
        o_stat.len_start   = eff_len(i_cfg.start_len);
        o_stat.len_end     = eff_len(i_cfg.end_len);
        o_stat.len_stuff   = eff_len(i_cfg.stuff_len);
        o_stat.match_start = f_match(i_cfg.start_pat, o_stat.len_start, r_win, r_fill);
        o_stat.match_end   = f_match(i_cfg.end_pat, o_stat.len_end, r_win, r_fill);
        o_stat.match_esc   = f_match(i_cfg.esc_pat, eff_len(i_cfg.esc_len), r_win, r_fill);
        o_stat.push_ok     = !r_pend_v || out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_inside   <= 1'b0;
            r_item_end <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                unique case (i_ctl.cls)
                    CLS_STORE: r_fill <= r_fill + FILL_W'(1);
                    CLS_RELEASE: begin
                        r_fill     <= FILL_W'(MAX_PATTERN_BYTES);
                        r_item_end <= 1'b0;
                    end
                    CLS_BEGIN: begin
                        r_inside   <= 1'b1;
                        r_fill     <= '0;
                        r_item_end <= 1'b0;
                    end
                    CLS_END: begin
                        r_inside   <= 1'b0;
                        r_item_end <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.shift) begin
                r_fill <= r_fill - FILL_W'(1);
            end
            if (i_ctl.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_ctl.finish) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_ctl.cls == CLS_STORE) begin
            r_win[r_fill[IDX_W-1:0]] <= i_data_byte;
        end else if (i_ctl.accept && i_ctl.cls == CLS_RELEASE) begin
            r_win[MAX_PATTERN_BYTES-1] <= i_data_byte;
        end else if (i_ctl.shift) begin
            for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
        if (i_ctl.emit) begin
            r_pend_byte <= sel_byte;
        end
        if (push) begin
            r_out_byte <= r_pend_byte;
            r_out_last <= i_ctl.finish;
            r_out_fd   <= i_ctl.finish & r_item_end;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_frame_done  = r_out_fd;

endmodule

// ===== sv/mbds_seq.sv =====
// ----------------------------------------------------------------------------
// mbds_seq
// Microcode sequencer: step counter, control store and pattern byte counter.
// ----------------------------------------------------------------------------
module mbds_seq
    import mbds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [1:0]  i_action,
    input  t_stat       i_stat,
    output logic        o_in_stall,
    output t_ctl        o_ctl
);

    typedef logic [3:0] t_step;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_JUMP,
        OP_EMIT,
        OP_SHIFT,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_START,
        C_NO_END,
        C_NO_ESC,
        C_DATA_ITEM,
        C_FILL
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_src  src;
        t_step target;
    } t_uinst;

    localparam t_step S_FETCH  = 4'd0;
    localparam t_step S_REL    = 4'd1;
    localparam t_step S_CK_END = 4'd3;
    localparam t_step S_CK_ESC = 4'd5;
    localparam t_step S_HEAD   = 4'd7;
    localparam t_step S_SHIFT  = 4'd8;
    localparam t_step S_FLUSH  = 4'd9;
    localparam t_step S_FINISH = 4'd11;
    localparam t_step S_BEGIN  = 4'd12;

    function automatic t_uinst f_rom(input t_step s);
        t_uinst u;
        unique case (s)
            4'd0:    u = '{OP_FETCH,  C_ALWAYS,    SRC_HEAD,  S_FETCH};
            4'd1:    u = '{OP_JUMP,   C_NO_START,  SRC_HEAD,  S_CK_END};
            4'd2:    u = '{OP_EMIT,   C_ALWAYS,    SRC_START, S_CK_END};
            4'd3:    u = '{OP_JUMP,   C_NO_END,    SRC_HEAD,  S_CK_ESC};
            4'd4:    u = '{OP_EMIT,   C_ALWAYS,    SRC_END,   S_CK_ESC};
            4'd5:    u = '{OP_JUMP,   C_NO_ESC,    SRC_HEAD,  S_HEAD};
            4'd6:    u = '{OP_EMIT,   C_ALWAYS,    SRC_STUFF, S_HEAD};
            4'd7:    u = '{OP_EMIT,   C_ALWAYS,    SRC_HEAD,  S_SHIFT};
            4'd8:    u = '{OP_SHIFT,  C_DATA_ITEM, SRC_HEAD,  S_FINISH};
            4'd9:    u = '{OP_JUMP,   C_FILL,      SRC_HEAD,  S_REL};
            4'd10:   u = '{OP_EMIT,   C_ALWAYS,    SRC_END,   S_FINISH};
            4'd11:   u = '{OP_FINISH, C_ALWAYS,    SRC_HEAD,  S_FETCH};
            4'd12:   u = '{OP_EMIT,   C_ALWAYS,    SRC_START, S_FINISH};
            default: u = '{OP_FINISH, C_ALWAYS,    SRC_HEAD,  S_FETCH};
        endcase
        return u;
    endfunction

    t_step          r_step, n_step;
    logic [K_W-1:0] r_k, n_k;
    t_uinst         u;
    t_cls           cls;
    logic           cond_hit;
    logic [LEN_W-1:0] len;

    assign u = f_rom(r_step);

    always_comb begin
        unique case (u.cond)
            C_NO_START:  cond_hit = !i_stat.match_start;
            C_NO_END:    cond_hit = !i_stat.match_end;
            C_NO_ESC:    cond_hit = !i_stat.match_esc;
            C_DATA_ITEM: cond_hit = !i_stat.item_end;
            C_FILL:      cond_hit = i_stat.fill_nz;
            default:     cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        unique case (u.src)
            SRC_START: len = i_stat.len_start;
            SRC_END:   len = i_stat.len_end;
            SRC_STUFF: len = i_stat.len_stuff;
            SRC_HEAD:  len = LEN_W'(1);
        endcase
    end

    always_comb begin
        unique case (i_action)
            ACT_DATA:  cls = !i_stat.in_frame ? CLS_IGNORE :
                             (i_stat.fill_full ? CLS_RELEASE : CLS_STORE);
            ACT_BEGIN: cls = i_stat.in_frame ? CLS_IGNORE : CLS_BEGIN;
            ACT_END:   cls = i_stat.in_frame ? CLS_END : CLS_IGNORE;
            default:   cls = CLS_IGNORE;
        endcase
    end

    always_comb begin
        n_step       = r_step;
        n_k          = r_k;
        o_ctl.accept = 1'b0;
        o_ctl.cls    = cls;
        o_ctl.emit   = 1'b0;
        o_ctl.src    = u.src;
        o_ctl.k      = r_k;
        o_ctl.shift  = 1'b0;
        o_ctl.finish = 1'b0;
        unique case (u.op)
            OP_FETCH: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    unique case (cls)
                        CLS_RELEASE: n_step = S_REL;
                        CLS_BEGIN:   n_step = S_BEGIN;
                        CLS_END:     n_step = S_FLUSH;
                        default:     n_step = S_FETCH;
                    endcase
                end
            end
            OP_JUMP: begin
                n_step = cond_hit ? u.target : r_step + 4'd1;
            end
            OP_EMIT: begin
                if (len == '0) begin
                    n_step = u.target;
                end else if (i_stat.push_ok) begin
                    o_ctl.emit = 1'b1;
                    if (LEN_W'(r_k) + LEN_W'(1) == len) begin
                        n_k    = '0;
                        n_step = u.target;
                    end else begin
                        n_k = r_k + K_W'(1);
                    end
                end
            end
            OP_SHIFT: begin
                o_ctl.shift = 1'b1;
                n_step      = cond_hit ? u.target : r_step + 4'd1;
            end
            OP_FINISH: begin
                if (i_stat.push_ok) begin
                    o_ctl.finish = 1'b1;
                    n_step       = S_FETCH;
                end
            end
        endcase
    end

    assign o_in_stall = (u.op != OP_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
            r_k    <= '0;
        end else begin
            r_step <= n_step;
            r_k    <= n_k;
        end
    end

endmodule

// ===== sv/multi_byte_delimiter_stuffer_top.sv =====
// ----------------------------------------------------------------------------
// multi_byte_delimiter_stuffer_top
// Frames a byte stream between multi-byte delimiters with byte stuffing.
//
//   port group     direction  handshake              payload
//   input words    in         i_in_valid/o_in_stall  i_action, i_data_byte
//   output words   out        o_out_valid/i_out_stall o_out_byte, o_last_of_run,
//                                                    o_frame_done
//   configuration  in/out     psel/penable/pready    paddr, pwdata, prdata
//
// a buffered data byte is stored in the fetch step; a released byte steps
// through the start, end and escape checks, the insertion for each match,
// the head byte, the shift and the finish, all stepped by the microcode
// sequencer; an end word runs the release loop once per buffered byte, then
// the end delimiter. each word leaves through a one-byte hold stage and the
// output register, so output stalls hold only the emit and finish steps.
// reset is synchronous; the window is empty and no frame is open after it.
// ----------------------------------------------------------------------------
module multi_byte_delimiter_stuffer_top
    import mbds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run,
    output logic              o_frame_done
);

    t_cfg  cfg;
    t_ctl  ctl;
    t_stat stat;

    mbds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbds_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    mbds_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_ctl         (ctl),
        .i_data_byte   (i_data_byte),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

endmodule

// ===== dv/multi_byte_delimiter_stuffer_top_tb.sv =====
// ----------------------------------------------------------------------------
// multi_byte_delimiter_stuffer_top_tb
// Self-checking bench for the delimiter stuffer. The registers are loaded
// over the apb port. Framed byte streams go in with random bursts and gaps,
// and the receiver stalls on its own pattern. Every output word is compared
// in order with the bytes that a behavioural predictor of the framing and
// stuffing rules expects. Directed frames cover the reset settings, pattern
// matches, oversized and zero lengths and ignored words. Random frames are
// then built from pieces of the configured patterns, and a last frame meets
// a long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module multi_byte_delimiter_stuffer_top_tb
    import mbds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  ACT_RSVD     = 2'd3;
    localparam logic [31:0] ESC_RESET    = 32'h0063_7365;
    localparam int          DRAIN_CYCLES = 200;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       done;
    } t_out_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_action;
    logic [7:0]        i_data_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_out_byte;
    logic              o_last_of_run;
    logic              o_frame_done;

    multi_byte_delimiter_stuffer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // predictor state
    t_cfg        shadow_cfg;
    t_win        win_bytes;
    int          win_fill;
    logic        frame_open;
    t_out_word   expected_bytes[$];

    int          errors;
    int          sent_words;
    int          burst_left;
    bit          gaps_on;
    t_stall_mode stall_mode;
    int          hold_len;
    int          stall_cyc;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int clamp_len(input logic [CFG_LEN_W-1:0] len);
        return (int'(len) > PAT_LIMIT) ? PAT_LIMIT : int'(len);
    endfunction

    function automatic bit pattern_hit(input logic [31:0] pat,
                                       input logic [CFG_LEN_W-1:0] len,
                                       input t_win seq, input int avail);
        int n;
        n = clamp_len(len);
        if (n > avail) return 1'b0;
        for (int k = 0; k < n; k++) begin
            if (seq[k] != pat[8*(k%4) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_pattern(input logic [31:0] pat,
                                         input logic [CFG_LEN_W-1:0] len);
        t_out_word w;
        for (int k = 0; k < clamp_len(len); k++) begin
            w.b    = pat[8*(k%4) +: 8];
            w.last = 1'b0;
            w.done = 1'b0;
            expected_bytes.push_back(w);
        end
    endfunction

    function automatic void release_byte(input t_win seq, input int avail);
        t_out_word w;
        if (pattern_hit(shadow_cfg.start_pat, shadow_cfg.start_len, seq, avail))
            push_pattern(shadow_cfg.start_pat, shadow_cfg.start_len);
        if (pattern_hit(shadow_cfg.end_pat, shadow_cfg.end_len, seq, avail))
            push_pattern(shadow_cfg.end_pat, shadow_cfg.end_len);
        if (pattern_hit(shadow_cfg.esc_pat, shadow_cfg.esc_len, seq, avail))
            push_pattern(shadow_cfg.stuff_pat, shadow_cfg.stuff_len);
        w.b    = seq[0];
        w.last = 1'b0;
        w.done = 1'b0;
        expected_bytes.push_back(w);
    endfunction

    function automatic void predict_framing(input logic [1:0] act, input logic [7:0] data);
        int   first;
        t_win seq;
        first = expected_bytes.size();
        if (act == ACT_DATA) begin
            if (!frame_open) return;
            if (win_fill < WIN_DEPTH) begin
                win_bytes[win_fill] = data;
                win_fill++;
                return;
            end
            seq = win_bytes;
            seq[WIN_DEPTH] = data;
            release_byte(seq, MAX_PATTERN_BYTES);
            win_bytes = seq >> 8;
        end else if (act == ACT_BEGIN) begin
            if (frame_open) return;
            frame_open = 1'b1;
            win_fill   = 0;
            push_pattern(shadow_cfg.start_pat, shadow_cfg.start_len);
        end else if (act == ACT_END) begin
            if (!frame_open) return;
            for (int i = 0; i < win_fill; i++) begin
                seq = win_bytes >> (8*i);
                release_byte(seq, win_fill - i);
            end
            push_pattern(shadow_cfg.end_pat, shadow_cfg.end_len);
            win_fill   = 0;
            frame_open = 1'b0;
            if (expected_bytes.size() > first)
                expected_bytes[expected_bytes.size()-1].done = 1'b1;
        end else begin
            return;
        end
        if (expected_bytes.size() > first)
            expected_bytes[expected_bytes.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                if (errors < 10)
                    $display("unexpected word: byte %02h last %0b done %0b",
                             o_out_byte, o_last_of_run, o_frame_done);
                errors++;
            end else begin
                e = expected_bytes.pop_front();
                if (o_out_byte !== e.b || o_last_of_run !== e.last ||
                    o_frame_done !== e.done) begin
                    if (errors < 10)
                        $display("mismatch: exp byte %02h last %0b done %0b, got %02h %0b %0b",
                                 e.b, e.last, e.done, o_out_byte, o_last_of_run,
                                 o_frame_done);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern and long hold
    // ------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        stall_cyc   = 0;
        forever begin
            @(negedge i_clk);
            stall_cyc++;
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                hold_len--;
            end else begin
                case (stall_mode)
                    STALL_RANDOM:   i_out_stall <= ($urandom_range(99) < 40);
                    STALL_PERIODIC: i_out_stall <= ((stall_cyc % 7) < 3);
                    default:        i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input t_reg idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_START_PAT: shadow_cfg.start_pat = val;
            REG_START_LEN: shadow_cfg.start_len = val[CFG_LEN_W-1:0];
            REG_END_PAT:   shadow_cfg.end_pat   = val;
            REG_END_LEN:   shadow_cfg.end_len   = val[CFG_LEN_W-1:0];
            REG_ESC_PAT:   shadow_cfg.esc_pat   = val;
            REG_ESC_LEN:   shadow_cfg.esc_len   = val[CFG_LEN_W-1:0];
            REG_STUFF_PAT: shadow_cfg.stuff_pat = val;
            REG_STUFF_LEN: shadow_cfg.stuff_len = val[CFG_LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input logic [31:0] sp, input int sl,
                               input logic [31:0] ep, input int el,
                               input logic [31:0] xp, input int xl,
                               input logic [31:0] fp, input int fl);
        write_reg(REG_START_PAT, sp);
        write_reg(REG_START_LEN, 32'(sl));
        write_reg(REG_END_PAT,   ep);
        write_reg(REG_END_LEN,   32'(el));
        write_reg(REG_ESC_PAT,   xp);
        write_reg(REG_ESC_LEN,   32'(xl));
        write_reg(REG_STUFF_PAT, fp);
        write_reg(REG_STUFF_LEN, 32'(fl));
    endtask

    task automatic send_word(input logic [1:0] act, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            gap = gaps_on ? $urandom_range(6) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_in_stall);
        predict_framing(act, data);
        sent_words++;
    endtask

    // wait for every expected word, then for the block to go quiet
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pattern_piece();
        logic [31:0] p;
        case ($urandom_range(3))
            0:       p = shadow_cfg.start_pat;
            1:       p = shadow_cfg.end_pat;
            2:       p = shadow_cfg.esc_pat;
            default: p = shadow_cfg.stuff_pat;
        endcase
        return p[8*$urandom_range(3) +: 8];
    endfunction

    task automatic send_pattern_bytes();
        logic [31:0] p;
        int          n;
        case ($urandom_range(2))
            0:       begin p = shadow_cfg.start_pat; n = clamp_len(shadow_cfg.start_len); end
            1:       begin p = shadow_cfg.end_pat;   n = clamp_len(shadow_cfg.end_len);   end
            default: begin p = shadow_cfg.esc_pat;   n = clamp_len(shadow_cfg.esc_len);   end
        endcase
        if (n > 1 && $urandom_range(99) < 20) n = $urandom_range(n - 1, 1);
        for (int k = 0; k < n; k++) send_word(ACT_DATA, p[8*k +: 8]);
    endtask

    task automatic send_random_frame(input int max_len);
        int n;
        int r;
        if ($urandom_range(99) < 8) send_word(2'($urandom_range(3)), 8'($urandom));
        send_word(ACT_BEGIN, 8'($urandom));
        n = $urandom_range(max_len);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 25)
                send_pattern_bytes();
            else if (r < 29)
                send_word(($urandom_range(1) != 0) ? ACT_RSVD : ACT_BEGIN, 8'($urandom));
            else if (r < 65)
                send_word(ACT_DATA, pattern_piece());
            else
                send_word(ACT_DATA, 8'($urandom));
        end
        if ($urandom_range(99) < 92) send_word(ACT_END, 8'($urandom));
    endtask

    function automatic logic [31:0] random_pattern(input bit narrow);
        logic [31:0] p;
        logic [7:0]  sym [4];
        sym = '{8'h00, 8'hFF, 8'h7E, 8'h7D};
        p = $urandom;
        if (narrow) begin
            for (int k = 0; k < 4; k++) p[8*k +: 8] = sym[$urandom_range(3)];
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_settings();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        send_word(ACT_DATA, 8'h55);
        send_word(ACT_END, 8'h00);
        send_word(ACT_RSVD, 8'hFF);
        send_word(ACT_BEGIN, 8'h00);
        send_word(ACT_DATA, 8'h65);
        send_word(ACT_DATA, 8'h73);
        send_word(ACT_DATA, 8'h63);
        send_word(ACT_DATA, 8'h65);
        send_word(ACT_END, 8'h00);
        wait_idle();
    endtask

    task automatic test_delimiter_matches();
        load_config(32'h0403_0201, 4, 32'h0000_FFEE, 2,
                    32'hFFFF_FF00, 1, 32'h7D7C_7B7A, 7);
        stall_mode = STALL_PERIODIC;
        send_word(ACT_BEGIN, 8'h00);
        send_word(ACT_DATA, 8'h01);
        send_word(ACT_DATA, 8'h02);
        send_word(ACT_DATA, 8'h03);
        send_word(ACT_DATA, 8'h04);
        send_word(ACT_DATA, 8'hEE);
        send_word(ACT_DATA, 8'hFF);
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_BEGIN, 8'hFF);
        send_word(ACT_RSVD, 8'h00);
        send_word(ACT_DATA, 8'hFF);
        send_word(ACT_DATA, 8'h03);
        send_word(ACT_DATA, 8'hEE);
        send_word(ACT_END, 8'hFF);
        wait_idle();
    endtask

    task automatic test_zero_lengths();
        load_config(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0,
                    32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
        stall_mode = STALL_RANDOM;
        send_word(ACT_BEGIN, 8'h00);
        send_word(ACT_END, 8'h00);
        send_word(ACT_BEGIN, 8'h00);
        send_word(ACT_DATA, 8'hAA);
        send_word(ACT_DATA, 8'h55);
        send_word(ACT_END, 8'h00);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int target;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: load_config(random_pattern(1), 4, random_pattern(1), 4,
                               random_pattern(1), 4, random_pattern(0), 4);
                1: load_config(random_pattern(0), $urandom_range(7),
                               random_pattern(0), $urandom_range(7),
                               random_pattern(1), $urandom_range(7),
                               random_pattern(0), $urandom_range(7));
                2: load_config(32'h7E7E_7E7E, 1, 32'h7D7E_7E7E, 3,
                               32'h7E7E_7E7E, 2, random_pattern(0), 0);
                default: load_config(random_pattern(1), $urandom_range(4),
                                     random_pattern(1), $urandom_range(4),
                                     random_pattern(1), $urandom_range(4),
                                     random_pattern(0), $urandom_range(4));
            endcase
            gaps_on    = (ph != 2);
            stall_mode = t_stall_mode'(ph % 3);
            target     = sent_words + 25;
            while (sent_words < target) send_random_frame(10);
            wait_idle();
        end
    endtask

    task automatic test_output_hold();
        load_config(32'h0000_007E, 1, 32'h0000_7E7D, 2,
                    32'h0000_007D, 1, 32'h5E5D_5C5B, 4);
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        @(posedge i_clk);
        hold_len = 400;
        send_word(ACT_BEGIN, 8'h00);
        for (int k = 0; k < 18; k++)
            send_word(ACT_DATA, ($urandom_range(1) != 0) ? 8'h7D : 8'h7E);
        send_word(ACT_END, 8'h00);
        wait_idle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_in_valid  = 1'b0;
        i_action    = ACT_DATA;
        i_data_byte = 8'h00;
        errors      = 0;
        sent_words  = 0;
        burst_left  = 0;
        gaps_on     = 1'b0;
        stall_mode  = STALL_NONE;
        hold_len    = 0;
        win_bytes   = '0;
        win_fill    = 0;
        frame_open  = 1'b0;
        shadow_cfg  = '0;
        shadow_cfg.esc_pat = ESC_RESET;
        shadow_cfg.esc_len = CFG_LEN_W'(3);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        test_reset_settings();
        test_delimiter_matches();
        test_zero_lengths();
        test_random_frames();
        test_output_hold();

        wait_idle();
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
